### rtl/triangle_longest_edge_select_defines.svh
// Assertion macros for the block's top-level RTL.
`ifndef TRIANGLE_LONGEST_EDGE_SELECT_DEFINES_SVH
`define TRIANGLE_LONGEST_EDGE_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLES_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLES_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tles_pkg.sv
`timescale 1ns / 1ps

package tles_pkg;

    // Default coordinate width.
    localparam int COORD_BITS_DEF = 24;

    // Tolerance register width.
    localparam int TOL_W = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

    // Edge codes; an edge runs from vertex i to vertex (i + 1) mod 3.
    localparam logic [1:0] EDGE_01 = 2'd0;
    localparam logic [1:0] EDGE_12 = 2'd1;
    localparam logic [1:0] EDGE_20 = 2'd2;

    // Vertex codes.
    localparam logic [1:0] VTX_0 = 2'd0;
    localparam logic [1:0] VTX_1 = 2'd1;
    localparam logic [1:0] VTX_2 = 2'd2;

    // Axis positions within one vertex.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Tie-break outcomes: set when the first named vertex wins (y first, then x).
    typedef struct packed {
        logic w12;  // vertex 1 over vertex 2
        logic w02;  // vertex 0 over vertex 2
        logic w10;  // vertex 1 over vertex 0
    } tles_tie_t;

endpackage

### rtl/triangle_longest_edge_select.sv
`timescale 1ns / 1ps
//  Channel   Dir  Handshake          Contents
//  config    in   cfg_wen            cfg_idx selects the height enable or tolerance
//  s_        in   s_tvalid/s_tready  one triangle per beat
//  m_        out  m_tvalid/m_tready  one result per beat
//
//  One triangle is taken per cycle while s_tready is high; its result passes through the
//  input, square, length and result registers in turn (up to four in flight).
//  Subtract and 24x24 square, the three-term add, then compare and select set the split.
//  Reset (aresetn low, synchronous) clears the valid bits and configuration registers.
//  A stall on m_ backs up stage by stage; empty stages still take beats.
`include "triangle_longest_edge_select_defines.svh"

module triangle_longest_edge_select #(
    parameter  int COORD_BITS = tles_pkg::COORD_BITS_DEF,
    localparam int IN_W       = 9 * COORD_BITS + 3,
    localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 2 * COORD_BITS + 5,
    localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [tles_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [tles_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    // v0_on_border, v1_on_border, v2_on_border, zero fill
    input  logic [S_TDATA_W-1:0]               s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // longest_edge, opposite_vertex, mid_x, mid_y, mid_on_border, zero fill
    output logic [M_TDATA_W-1:0]               m_tdata
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int LEN_W = 2 * COORD_BITS + 2;

    logic                             height_en_reg;
    logic [tles_pkg::TOL_W-1:0]       tolerance_reg;

    logic [IN_W-1:0]                  in_data_reg;
    logic                             in_valid_reg;
    logic                             sqr_valid_reg;
    logic                             len_valid_reg;
    logic                             out_valid_reg;
    logic                             in_rdy, sqr_rdy, len_rdy, out_rdy;

    logic [2:0][2:0][COORD_BITS-1:0]  vtx;
    logic [2:0]                       bord;

    logic [2:0][2:0][SQ_W-1:0]        sqr_sq;
    logic [2:0][COORD_BITS-1:0]       sqr_mx, sqr_my;
    logic [2:0]                       sqr_eb;
    tles_pkg::tles_tie_t              sqr_tie;

    logic [2:0][LEN_W-1:0]            len_len;
    logic [2:0][COORD_BITS-1:0]       len_mx, len_my;
    logic [2:0]                       len_eb;
    tles_pkg::tles_tie_t              len_tie;

    logic [1:0]                       res_edge, res_opp;
    logic [COORD_BITS-1:0]            res_mx, res_my;
    logic                             res_mb;

    logic                             opp_ok;
    logic                             all_full;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_en_reg <= 1'b0;
            tolerance_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_idx)
                tles_pkg::REG_HEIGHT_EN: height_en_reg <= cfg_wdata[0];
                tles_pkg::REG_TOLERANCE: tolerance_reg <= cfg_wdata[tles_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage moves on when it is empty or the next one moves on.
    assign out_rdy  = !out_valid_reg || m_tready;
    assign len_rdy  = !len_valid_reg || out_rdy;
    assign sqr_rdy  = !sqr_valid_reg || len_rdy;
    assign in_rdy   = !in_valid_reg  || sqr_rdy;
    assign s_tready = in_rdy;

    // Valid bits of the four stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            sqr_valid_reg <= 1'b0;
            len_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_rdy) begin
                in_valid_reg <= s_tvalid;
            end
            if (sqr_rdy) begin
                sqr_valid_reg <= in_valid_reg;
            end
            if (len_rdy) begin
                len_valid_reg <= sqr_valid_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= len_valid_reg;
            end
        end
    end

    // Input register holds the triangle beat.
    always_ff @(posedge aclk) begin
        if (in_rdy) begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
    end

    // Unpack the vertices and border flags.
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int a = 0; a < 3; a++) begin
                vtx[v][a] = in_data_reg[(3 * v + a) * COORD_BITS +: COORD_BITS];
            end
            bord[v] = in_data_reg[9 * COORD_BITS + v];
        end
    end

    tles_sqr #(
        .COORD_BITS (COORD_BITS)
    ) u_sqr (
        .aclk      (aclk),
        .en        (sqr_rdy),
        .tolerance (tolerance_reg),
        .vtx       (vtx),
        .bord      (bord),
        .sq_reg    (sqr_sq),
        .mid_x_reg (sqr_mx),
        .mid_y_reg (sqr_my),
        .ebord_reg (sqr_eb),
        .tie_reg   (sqr_tie)
    );

    tles_len #(
        .COORD_BITS (COORD_BITS)
    ) u_len (
        .aclk       (aclk),
        .en         (len_rdy),
        .height_en  (height_en_reg),
        .sq         (sqr_sq),
        .mid_x      (sqr_mx),
        .mid_y      (sqr_my),
        .ebord      (sqr_eb),
        .tie        (sqr_tie),
        .len_reg    (len_len),
        .mid_x_reg  (len_mx),
        .mid_y_reg  (len_my),
        .ebord_reg  (len_eb),
        .tie_reg    (len_tie)
    );

    tles_pick #(
        .COORD_BITS (COORD_BITS)
    ) u_pick (
        .aclk         (aclk),
        .en           (out_rdy),
        .tolerance    (tolerance_reg),
        .len          (len_len),
        .mid_x        (len_mx),
        .mid_y        (len_my),
        .ebord        (len_eb),
        .tie          (len_tie),
        .lng_edge_reg (res_edge),
        .opp_vtx_reg  (res_opp),
        .mid_x_reg    (res_mx),
        .mid_y_reg    (res_my),
        .mid_bord_reg (res_mb)
    );

    // Result beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({res_mb, res_my, res_mx, res_opp, res_edge});

    // Terms used by the checks below.
    assign opp_ok   = (res_edge == tles_pkg::EDGE_01 && res_opp == tles_pkg::VTX_2)
                   || (res_edge == tles_pkg::EDGE_12 && res_opp == tles_pkg::VTX_0)
                   || (res_edge == tles_pkg::EDGE_20 && res_opp == tles_pkg::VTX_1);
    assign all_full = in_valid_reg && sqr_valid_reg && len_valid_reg && out_valid_reg;

    // The opposite vertex always matches the chosen edge.
    `TLES_ASSERT_NOW(a_opp_matches_edge, aclk, aresetn, m_tvalid, opp_ok, "opposite vertex mismatch")
    // A full pipeline with a stalled output takes no new beat.
    `TLES_ASSERT_NOW(a_full_blocks_input, aclk, aresetn, all_full && !m_tready, !s_tready, "beat taken when full")
    // A result only appears behind a valid length stage.
    `TLES_ASSERT_NOW(a_result_has_source, aclk, aresetn, $rose(m_tvalid), $past(len_valid_reg), "result without source")

endmodule

### rtl/tles_sqr.sv
`timescale 1ns / 1ps

// Square stage, after the input register: per-axis edge differences and their squares,
// edge midpoints, edge border flags and the coordinate tie-break decisions.
module tles_sqr #(
    parameter int COORD_BITS = tles_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [tles_pkg::TOL_W-1:0]              tolerance,
    input  logic [2:0][2:0][COORD_BITS-1:0]         vtx,
    input  logic [2:0]                              bord,
    output logic [2:0][2:0][2*COORD_BITS-1:0]       sq_reg,
    output logic [2:0][COORD_BITS-1:0]              mid_x_reg,
    output logic [2:0][COORD_BITS-1:0]              mid_y_reg,
    output logic [2:0]                              ebord_reg,
    output tles_pkg::tles_tie_t                     tie_reg
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam int CMP_W = (DW > tles_pkg::TOL_W) ? DW : tles_pkg::TOL_W;

    logic [2:0][2:0][SQ_W-1:0]       sq_next;
    logic [2:0][COORD_BITS-1:0]      mid_x_next;
    logic [2:0][COORD_BITS-1:0]      mid_y_next;
    logic [2:0]                      ebord_next;
    tles_pkg::tles_tie_t             tie_next;

    // Signed a > b with a margin larger than the tolerance.
    function automatic logic s_gt(input logic [COORD_BITS-1:0] a,
                                  input logic [COORD_BITS-1:0] b,
                                  input logic [tles_pkg::TOL_W-1:0] tol);
        logic [DW-1:0] d;
        begin
            d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
            s_gt = !d[DW-1] && (CMP_W'(d) > CMP_W'(tol));
        end
    endfunction

    // Vertex p beats vertex q on y, or on x when the y values are equal within the tolerance.
    function automatic logic wins(input logic [COORD_BITS-1:0] px,
                                  input logic [COORD_BITS-1:0] py,
                                  input logic [COORD_BITS-1:0] qx,
                                  input logic [COORD_BITS-1:0] qy,
                                  input logic [tles_pkg::TOL_W-1:0] tol);
        begin
            wins = s_gt(py, qy, tol) || (!s_gt(qy, py, tol) && s_gt(px, qx, tol));
        end
    endfunction

    // Squares, midpoints and border flags for each edge.
    for (genvar e = 0; e < 3; e++) begin : g_edge
        localparam int J = (e + 1) % 3;
        logic [DW-1:0] sum_x;
        logic [DW-1:0] sum_y;

        for (genvar a = 0; a < 3; a++) begin : g_axis
            logic [DW-1:0]         d;
            logic [DW-1:0]         nd;
            logic [COORD_BITS-1:0] mag;

            assign d   = {vtx[e][a][COORD_BITS-1], vtx[e][a]}
                       - {vtx[J][a][COORD_BITS-1], vtx[J][a]};
            assign nd  = -d;
            assign mag = d[DW-1] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
            assign sq_next[e][a] = SQ_W'(mag) * SQ_W'(mag);
        end

        // Floor of the half sum is the sum shifted right arithmetically.
        assign sum_x = {vtx[e][tles_pkg::AXIS_X][COORD_BITS-1], vtx[e][tles_pkg::AXIS_X]}
                     + {vtx[J][tles_pkg::AXIS_X][COORD_BITS-1], vtx[J][tles_pkg::AXIS_X]};
        assign sum_y = {vtx[e][tles_pkg::AXIS_Y][COORD_BITS-1], vtx[e][tles_pkg::AXIS_Y]}
                     + {vtx[J][tles_pkg::AXIS_Y][COORD_BITS-1], vtx[J][tles_pkg::AXIS_Y]};
        assign mid_x_next[e] = sum_x[DW-1:1];
        assign mid_y_next[e] = sum_y[DW-1:1];
        assign ebord_next[e] = bord[e] & bord[J];
    end

    // Tie-break decisions for each pair of edges.
    always_comb begin
        tie_next.w12 = wins(vtx[1][tles_pkg::AXIS_X], vtx[1][tles_pkg::AXIS_Y],
                            vtx[2][tles_pkg::AXIS_X], vtx[2][tles_pkg::AXIS_Y], tolerance);
        tie_next.w02 = wins(vtx[0][tles_pkg::AXIS_X], vtx[0][tles_pkg::AXIS_Y],
                            vtx[2][tles_pkg::AXIS_X], vtx[2][tles_pkg::AXIS_Y], tolerance);
        tie_next.w10 = wins(vtx[1][tles_pkg::AXIS_X], vtx[1][tles_pkg::AXIS_Y],
                            vtx[0][tles_pkg::AXIS_X], vtx[0][tles_pkg::AXIS_Y], tolerance);
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg    <= sq_next;
            mid_x_reg <= mid_x_next;
            mid_y_reg <= mid_y_next;
            ebord_reg <= ebord_next;
            tie_reg   <= tie_next;
        end
    end

endmodule

### rtl/tles_len.sv
`timescale 1ns / 1ps

// Length stage, after the square stage: squared edge lengths, with the height term when enabled.
module tles_len #(
    parameter int COORD_BITS = tles_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic                                    height_en,
    input  logic [2:0][2:0][2*COORD_BITS-1:0]       sq,
    input  logic [2:0][COORD_BITS-1:0]              mid_x,
    input  logic [2:0][COORD_BITS-1:0]              mid_y,
    input  logic [2:0]                              ebord,
    input  tles_pkg::tles_tie_t                     tie,
    output logic [2:0][2*COORD_BITS+1:0]            len_reg,
    output logic [2:0][COORD_BITS-1:0]              mid_x_reg,
    output logic [2:0][COORD_BITS-1:0]              mid_y_reg,
    output logic [2:0]                              ebord_reg,
    output tles_pkg::tles_tie_t                     tie_reg
);

    localparam int LEN_W = 2 * COORD_BITS + 2;

    logic [2:0][LEN_W-1:0] len_next;

    // Sum of the squared x and y differences for each edge, plus z when the height term is enabled.
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            len_next[e] = LEN_W'(sq[e][tles_pkg::AXIS_X]) + LEN_W'(sq[e][tles_pkg::AXIS_Y])
                        + (height_en ? LEN_W'(sq[e][tles_pkg::AXIS_Z]) : '0);
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg   <= len_next;
            mid_x_reg <= mid_x;
            mid_y_reg <= mid_y;
            ebord_reg <= ebord;
            tie_reg   <= tie;
        end
    end

endmodule

### rtl/tles_pick.sv
`timescale 1ns / 1ps

// Result stage, after the length stage: tolerant length compares, the edge decision tree and the
// selection of the chosen edge's midpoint and border flag.
module tles_pick #(
    parameter int COORD_BITS = tles_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [tles_pkg::TOL_W-1:0]              tolerance,
    input  logic [2:0][2*COORD_BITS+1:0]            len,
    input  logic [2:0][COORD_BITS-1:0]              mid_x,
    input  logic [2:0][COORD_BITS-1:0]              mid_y,
    input  logic [2:0]                              ebord,
    input  tles_pkg::tles_tie_t                     tie,
    output logic [1:0]                              lng_edge_reg,
    output logic [1:0]                              opp_vtx_reg,
    output logic [COORD_BITS-1:0]                   mid_x_reg,
    output logic [COORD_BITS-1:0]                   mid_y_reg,
    output logic                                    mid_bord_reg
);

    localparam int LEN_W = 2 * COORD_BITS + 2;

    logic                  g01, l01, g02, l02, g12, l12;
    logic [1:0]            edge_sel;
    logic [1:0]            opp_sel;
    logic [COORD_BITS-1:0] mx_sel;
    logic [COORD_BITS-1:0] my_sel;
    logic                  mb_sel;

    // Unsigned a > b with a margin larger than the tolerance.
    function automatic logic u_gt(input logic [LEN_W-1:0] a,
                                  input logic [LEN_W-1:0] b,
                                  input logic [tles_pkg::TOL_W-1:0] tol);
        logic [LEN_W:0] d;
        begin
            d = {1'b0, a} - {1'b0, b};
            u_gt = !d[LEN_W] && (d[LEN_W-1:0] > LEN_W'(tol));
        end
    endfunction

    // Pairwise length compares in both directions.
    always_comb begin
        g01 = u_gt(len[0], len[1], tolerance);
        l01 = u_gt(len[1], len[0], tolerance);
        g02 = u_gt(len[0], len[2], tolerance);
        l02 = u_gt(len[2], len[0], tolerance);
        g12 = u_gt(len[1], len[2], tolerance);
        l12 = u_gt(len[2], len[1], tolerance);
    end

    // Decision tree; equal lengths fall back to the vertex tie-breaks.
    always_comb begin
        if (g01) begin
            if (g02) begin
                edge_sel = tles_pkg::EDGE_01;
            end else if (!l02) begin
                edge_sel = tie.w12 ? tles_pkg::EDGE_20 : tles_pkg::EDGE_01;
            end else begin
                edge_sel = tles_pkg::EDGE_20;
            end
        end else if (!l01) begin
            if (!l02) begin
                edge_sel = tie.w02 ? tles_pkg::EDGE_12 : tles_pkg::EDGE_01;
            end else begin
                edge_sel = tles_pkg::EDGE_20;
            end
        end else begin
            if (g12) begin
                edge_sel = tles_pkg::EDGE_12;
            end else if (!l12) begin
                edge_sel = tie.w10 ? tles_pkg::EDGE_20 : tles_pkg::EDGE_12;
            end else begin
                edge_sel = tles_pkg::EDGE_20;
            end
        end
    end

    // Opposite vertex, midpoint and border flag of the chosen edge.
    always_comb begin
        case (edge_sel)
            tles_pkg::EDGE_01: begin
                opp_sel = tles_pkg::VTX_2;
                mx_sel  = mid_x[0];
                my_sel  = mid_y[0];
                mb_sel  = ebord[0];
            end
            tles_pkg::EDGE_12: begin
                opp_sel = tles_pkg::VTX_0;
                mx_sel  = mid_x[1];
                my_sel  = mid_y[1];
                mb_sel  = ebord[1];
            end
            default: begin
                opp_sel = tles_pkg::VTX_1;
                mx_sel  = mid_x[2];
                my_sel  = mid_y[2];
                mb_sel  = ebord[2];
            end
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (en) begin
            lng_edge_reg <= edge_sel;
            opp_vtx_reg  <= opp_sel;
            mid_x_reg    <= mx_sel;
            mid_y_reg    <= my_sel;
            mid_bord_reg <= mb_sel;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tles_pkg::*;

    localparam int CB      = COORD_BITS_DEF;
    localparam int S_W     = ((9 * CB + 3 + 7) / 8) * 8;
    localparam int M_W     = ((2 * CB + 5 + 7) / 8) * 8;
    localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;

    // One triangle as the block sees it; index i of each array is vertex i.
    typedef struct packed {
        logic [2:0]          border;
        logic [2:0][CB-1:0]  zc;
        logic [2:0][CB-1:0]  yc;
        logic [2:0][CB-1:0]  xc;
    } triangle_t;

    // One bisection result.
    typedef struct packed {
        logic [1:0]    long_edge;
        logic [1:0]    opp_vertex;
        logic [CB-1:0] mid_x;
        logic [CB-1:0] mid_y;
        logic          mid_border;
    } bisect_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;

    // Shadow copy of the configuration registers.
    logic              height_on = 1'b0;
    logic [TOL_W-1:0]  tol_value = '0;

    triangle_t pending_triangles[$];
    bisect_t   expected_bisections[$];
    triangle_t offered;
    bisect_t   seen_result;
    bisect_t   want_result;

    int  error_count    = 0;
    int  accepted_count = 0;
    int  checked_count  = 0;
    int  settings_count = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    bit  idle_on        = 1'b1;

    triangle_longest_edge_select #(
        .COORD_BITS(CB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // a "greater" b under the tolerance; the same test serves lengths and coordinates.
    function automatic bit exceeds(longint a, longint b, longint tol);
        return (a > b) && (a - b > tol);
    endfunction

    // Tie break between two edges: vertex p winning on y, then on x, picks hi.
    function automatic logic [1:0] tie_pick(longint yp, longint yq, longint xp, longint xq,
                                            longint tol, logic [1:0] hi, logic [1:0] lo);
        if (exceeds(yp, yq, tol)) return hi;
        if (exceeds(yq, yp, tol)) return lo;
        return exceeds(xp, xq, tol) ? hi : lo;
    endfunction

    function automatic bisect_t predict_bisection(triangle_t t, logic use_z, longint tol);
        longint px[3];
        longint py[3];
        longint pz[3];
        longint len[3];
        longint dx, dy, dz, half;
        logic [1:0] e;
        int a0, a1, j;
        bisect_t r;
        for (int i = 0; i < 3; i++) begin
            px[i] = longint'($signed(t.xc[i]));
            py[i] = longint'($signed(t.yc[i]));
            pz[i] = longint'($signed(t.zc[i]));
        end
        // Exact squared edge lengths, edge i runs from vertex i to the next.
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            dx = px[i] - px[j];
            dy = py[i] - py[j];
            dz = pz[i] - pz[j];
            len[i] = dx * dx + dy * dy;
            if (use_z) len[i] += dz * dz;
        end
        // Longest edge decision tree.
        if (exceeds(len[0], len[1], tol)) begin
            if (exceeds(len[0], len[2], tol))
                e = EDGE_01;
            else if (!exceeds(len[2], len[0], tol))
                e = tie_pick(py[1], py[2], px[1], px[2], tol, EDGE_20, EDGE_01);
            else
                e = EDGE_20;
        end else if (!exceeds(len[1], len[0], tol)) begin
            if (!exceeds(len[2], len[0], tol))
                e = tie_pick(py[0], py[2], px[0], px[2], tol, EDGE_12, EDGE_01);
            else
                e = EDGE_20;
        end else begin
            if (exceeds(len[1], len[2], tol))
                e = EDGE_12;
            else if (!exceeds(len[2], len[1], tol))
                e = tie_pick(py[1], py[0], px[1], px[0], tol, EDGE_20, EDGE_12);
            else
                e = EDGE_20;
        end
        a0 = int'(e);
        a1 = (a0 == 2) ? 0 : a0 + 1;
        r.long_edge = e;
        case (e)
            EDGE_01: r.opp_vertex = VTX_2;
            EDGE_12: r.opp_vertex = VTX_0;
            default: r.opp_vertex = VTX_1;
        endcase
        // Floor of the half sum is an arithmetic shift.
        half = (px[a0] + px[a1]) >>> 1;
        r.mid_x = half[CB-1:0];
        half = (py[a0] + py[a1]) >>> 1;
        r.mid_y = half[CB-1:0];
        r.mid_border = t.border[a0] & t.border[a1];
        return r;
    endfunction

    function automatic logic [S_W-1:0] pack_triangle(triangle_t t);
        logic [S_W-1:0] d;
        d = '0;
        for (int v = 0; v < 3; v++) begin
            d[(3 * v + AXIS_X) * CB +: CB] = t.xc[v];
            d[(3 * v + AXIS_Y) * CB +: CB] = t.yc[v];
            d[(3 * v + AXIS_Z) * CB +: CB] = t.zc[v];
            d[9 * CB + v] = t.border[v];
        end
        return d;
    endfunction

    function automatic triangle_t mk_tri(longint x0, longint y0, longint x1, longint y1,
                                         longint x2, longint y2);
        triangle_t t;
        t = '0;
        t.xc[0] = x0[CB-1:0];
        t.yc[0] = y0[CB-1:0];
        t.xc[1] = x1[CB-1:0];
        t.yc[1] = y1[CB-1:0];
        t.xc[2] = x2[CB-1:0];
        t.yc[2] = y2[CB-1:0];
        return t;
    endfunction

    // Hand-picked triangles: extremes, each tie-break branch, each edge winning.
    function automatic triangle_t directed_tri(int k);
        triangle_t t;
        case (k)
            0:  t = mk_tri(0, 0, 0, 0, 0, 0);
            1:  t = mk_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
            2:  t = mk_tri(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
            3:  t = mk_tri(-3, -7, 0, 4, 1, 1);
            // Edges 0 and 2 equal: y decides both ways, then x.
            4:  t = mk_tri(0, 0, 5, 0, 3, 4);
            5:  t = mk_tri(0, 0, 3, 4, 5, 0);
            6:  t = mk_tri(0, 0, 2, 5, -2, 5);
            7:  t = mk_tri(0, 0, -2, 5, 2, 5);
            // Edges 0 and 1 equal.
            8:  t = mk_tri(5, 0, 0, 0, 3, 4);
            9:  t = mk_tri(3, 4, 0, 0, 5, 0);
            10: t = mk_tri(2, 5, 0, 0, -2, 5);
            11: t = mk_tri(-2, 5, 0, 0, 2, 5);
            // Edges 1 and 2 equal.
            12: t = mk_tri(3, 4, 5, 0, 0, 0);
            13: t = mk_tri(5, 0, 3, 4, 0, 0);
            14: t = mk_tri(-2, 5, 2, 5, 0, 0);
            15: t = mk_tri(2, 5, -2, 5, 0, 0);
            // A clear winner on each edge, then edges 1 and 2 equal with a zero-length edge 0.
            16: t = mk_tri(0, 0, 10, 0, 1, 1);
            17: t = mk_tri(1, 1, 0, 0, 10, 0);
            18: t = mk_tri(10, 0, 1, 1, 0, 0);
            19: t = mk_tri(7, 7, 7, 7, -7, -7);
            // Height cases, used with the z term switched on.
            20: begin
                t = mk_tri(0, 0, 1, 0, 0, 1);
                t.zc[0] = CMIN[CB-1:0];
                t.zc[1] = CMAX[CB-1:0];
            end
            21: begin
                t = mk_tri(0, 0, 0, 0, 0, 0);
                t.zc[0] = CB'(5);
                t.zc[1] = CB'(-5);
            end
            22: begin
                t = mk_tri(0, 0, 5, 0, 3, 4);
                t.zc[2] = CB'(1);
            end
            default: begin
                t = mk_tri(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN);
                t.zc = {3{CMAX[CB-1:0]}};
            end
        endcase
        t.border = 3'(k);
        return t;
    endfunction

    function automatic longint rand_span(int s);
        return longint'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic longint pick_extreme();
        case ($urandom_range(0, 4))
            0:       return CMIN;
            1:       return CMAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // Random triangles: mostly clustered or isosceles shapes so that ties and
    // tolerance edges come up often, plus full-range and extreme coordinates.
    function automatic triangle_t rand_triangle();
        triangle_t t;
        int kind, spread, rot, m;
        longint bx, by, bz, a, b;
        longint vx[3];
        longint vy[3];
        longint vz[3];
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0:       spread = 3;
            1:       spread = 40;
            2:       spread = 300;
            default: spread = 3000;
        endcase
        bx = rand_span(1 << 22);
        by = rand_span(1 << 22);
        bz = rand_span(1 << 22);
        for (int i = 0; i < 3; i++) begin
            vx[i] = bx + rand_span(spread);
            vy[i] = by + rand_span(spread);
            vz[i] = bz + rand_span(spread);
        end
        if (kind < 2) begin
            for (int i = 0; i < 3; i++) begin
                vx[i] = longint'($urandom);
                vy[i] = longint'($urandom);
                vz[i] = longint'($urandom);
            end
        end else if (kind == 2) begin
            for (int i = 0; i < 3; i++) begin
                vx[i] = pick_extreme();
                vy[i] = pick_extreme();
                vz[i] = pick_extreme();
            end
        end else if (kind < 6) begin
            // Right isosceles with its apex on a random vertex.
            a = rand_span(spread);
            b = rand_span(spread);
            rot = $urandom_range(0, 2);
            m = $urandom_range(0, 1);
            vx[rot] = bx;
            vy[rot] = by;
            vx[(rot + 1 + m) % 3] = bx + a;
            vy[(rot + 1 + m) % 3] = by + b;
            vx[(rot + 2 - m) % 3] = bx - b;
            vy[(rot + 2 - m) % 3] = by + a;
            if ($urandom_range(0, 1) == 0) vz = '{bz, bz, bz};
        end
        for (int i = 0; i < 3; i++) begin
            t.xc[i] = vx[i][CB-1:0];
            t.yc[i] = vy[i][CB-1:0];
            t.zc[i] = vz[i][CB-1:0];
        end
        t.border = 3'($urandom_range(0, 7));
        return t;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %h, expected %h",
                                      checked_count, name, got, want));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        if (idx == REG_HEIGHT_EN)
            height_on = data[0];
        else
            tol_value = data[TOL_W-1:0];
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Wait until every queued triangle has gone in and every result has come out.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_triangles.size() != 0 || s_tvalid || expected_bisections.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] height_raw, logic [CFG_DATA_W-1:0] tol_raw,
                             int dir_lo, int dir_hi, int n_rand);
        write_reg(REG_HEIGHT_EN, height_raw);
        write_reg(REG_TOLERANCE, tol_raw);
        settings_count++;
        for (int k = dir_lo; k <= dir_hi; k++)
            pending_triangles.push_back(directed_tri(k));
        repeat (n_rand) pending_triangles.push_back(rand_triangle());
        wait_drained();
    endtask

    // Sender: offers queued triangles, with short random gaps between beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_bisections.push_back(predict_bisection(offered, height_on,
                                                                longint'(tol_value)));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (pending_triangles.size() != 0) begin
                    offered = pending_triangles.pop_front();
                    s_tdata  <= pack_triangle(offered);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and drives ready with stalls and one long hold.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_result.long_edge  = m_tdata[1:0];
                seen_result.opp_vertex = m_tdata[3:2];
                seen_result.mid_x      = m_tdata[4 +: CB];
                seen_result.mid_y      = m_tdata[4 + CB +: CB];
                seen_result.mid_border = m_tdata[4 + 2 * CB];
                if (expected_bisections.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing expected",
                                              checked_count));
                end else begin
                    want_result = expected_bisections.pop_front();
                    check_field("longest_edge", 64'(seen_result.long_edge),
                                64'(want_result.long_edge));
                    check_field("opposite_vertex", 64'(seen_result.opp_vertex),
                                64'(want_result.opp_vertex));
                    check_field("mid_x", 64'(seen_result.mid_x), 64'(want_result.mid_x));
                    check_field("mid_y", 64'(seen_result.mid_y), 64'(want_result.mid_y));
                    check_field("mid_on_border", 64'(seen_result.mid_border),
                                64'(want_result.mid_border));
                end
                checked_count++;
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog for a hung pipeline.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // Stray high bits in the height write must be dropped.
        run_phase(16'hFFFE, 16'h0000, 0, 19, 200);
        run_phase(16'h0001, 16'h0000, 20, 23, 240);
        // Widest tolerance, with the receiver holding off long enough to back up the input.
        hold_requests++;
        run_phase(16'h0000, 16'hFFFF, 1, 0, 240);
        run_phase(16'h8001, 16'($urandom_range(1, 4000)), 1, 0, 240);
        idle_on = 1'b0;
        run_phase(16'h0000, 16'd9, 1, 0, 240);
        if (expected_bisections.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_bisections.size()));
        $display("Checked %0d result beats from %0d triangles over %0d register settings,",
                 checked_count, accepted_count, settings_count);
        $display("covering 2D and 3D lengths, tolerance from 0 to full scale, and a long stall.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
